[rtl/lfu_sector_buffer_cache_defines.svh]
// assertion macros for the lfu sector buffer cache
// expects clk and rst_n in the scope of the including module
`ifndef LFU_SECTOR_BUFFER_CACHE_DEFINES_SVH
`define LFU_SECTOR_BUFFER_CACHE_DEFINES_SVH

// property must hold on every edge out of reset
`define LSBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lsbc assertion failed");

// condition must never be true out of reset
`define LSBC_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lsbc forbidden condition seen");

`endif

[rtl/lfu_sbc_pkg.sv]
// shared sizes, types and state codes of the lfu sector buffer cache
// no dependencies
`default_nettype none

package lfu_sbc_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SECTOR_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_BITS    = $clog2(SLOT_COUNT);

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [SECTOR_BITS-1:0] sector_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // search token walking the chain of slot cells
  typedef struct packed {
    logic    valid;
    sector_t sector;
    logic    hit;
    idx_t    hit_idx;
    logic    empty;
    idx_t    empty_idx;
    logic    have_min;
    count_t  min_count;
    idx_t    min_idx;
    logic    min_dirty;
    sector_t min_tag;
  } tok_t;

  // slot update broadcast after the search
  typedef struct packed {
    logic    valid;
    idx_t    idx;
    logic    hit;
    logic    read_only;
    sector_t sector;
  } upd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT
  } state_t;

endpackage

`default_nettype wire

[rtl/lfu_sbc_in_if.sv]
// request channel of the lfu sector buffer cache
// depends on lfu_sbc_pkg
`default_nettype none

interface lfu_sbc_in_if;
  logic                 valid;
  logic                 ready;
  lfu_sbc_pkg::sector_t sector_number;
  logic                 read_only;

  modport source (output valid, output sector_number, output read_only, input ready);
  modport sink   (input valid, input sector_number, input read_only, output ready);
endinterface

`default_nettype wire

[rtl/lfu_sbc_out_if.sv]
// result channel of the lfu sector buffer cache
// depends on lfu_sbc_pkg
`default_nettype none

interface lfu_sbc_out_if;
  logic                 valid;
  logic                 ready;
  lfu_sbc_pkg::idx_t    slot_index;
  logic                 was_hit;
  logic                 writeback_needed;
  lfu_sbc_pkg::sector_t writeback_sector;
  logic                 fill_needed;

  modport source (output valid, output slot_index, output was_hit, output writeback_needed,
                  output writeback_sector, output fill_needed, input ready);
  modport sink   (input valid, input slot_index, input was_hit, input writeback_needed,
                  input writeback_sector, input fill_needed, output ready);
endinterface

`default_nettype wire

[rtl/lfu_sector_buffer_cache.sv]
// top level of the lfu sector buffer cache: request control, chain of slot
// cells and result register; depends on lfu_sbc_pkg, the channel interfaces,
// lfu_sbc_cell and lfu_sector_buffer_cache_defines.svh
//
// Fully associative tag and least-frequently-used policy engine. A request
// (sector, read-only flag) is taken only when the engine is idle and sends a
// search token down a chain of SLOT_COUNT slot cells, one cell per cycle;
// the token gathers the hit slot, the first empty slot and the lowest-index
// slot with the smallest use count. When the token leaves the chain it is
// registered; once the output register is free, the chosen slot is updated and
// the result lands in the output register together. A new request is taken
// only after that, so the walk along the cell chain and any time the previous
// result waits in the output register set the gap between requests. All slots
// are empty after reset with no clearing pass.
`default_nettype none

`include "lfu_sector_buffer_cache_defines.svh"

module lfu_sector_buffer_cache (
  input wire logic      clk,
  input wire logic      rst_n,
  lfu_sbc_in_if.sink    in_ch,
  lfu_sbc_out_if.source out_ch
);

  localparam int N = lfu_sbc_pkg::SLOT_COUNT;

  lfu_sbc_pkg::state_t  state_r, state_nxt;
  lfu_sbc_pkg::tok_t    chain [N+1];
  lfu_sbc_pkg::tok_t    fin_r;
  lfu_sbc_pkg::upd_t    upd;
  logic                 ro_r;
  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;
  logic [N:0]           tok_valid_vec;

  logic                 out_valid_r, out_valid_nxt;
  lfu_sbc_pkg::idx_t    slot_index_r;
  logic                 was_hit_r;
  logic                 wb_needed_r;
  lfu_sbc_pkg::sector_t wb_sector_r;
  logic                 fill_needed_r;

  logic                 miss_evict;
  lfu_sbc_pkg::idx_t    res_idx;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // token injection
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = in_acc;
    chain[0].sector = in_ch.sector_number;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    lfu_sbc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfu_sbc_pkg::idx_t'(i)),
      .tok_i    (chain[i]),
      .upd      (upd),
      .tok_o    (chain[i+1])
    );
  end

  for (genvar i = 0; i <= N; i++) begin : g_vld
    assign tok_valid_vec[i] = chain[i].valid;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_sbc_pkg::S_IDLE:   if (in_acc) state_nxt = lfu_sbc_pkg::S_SEARCH;
      lfu_sbc_pkg::S_SEARCH: if (chain[N].valid) state_nxt = lfu_sbc_pkg::S_WAIT;
      lfu_sbc_pkg::S_WAIT:   if (out_free) state_nxt = lfu_sbc_pkg::S_IDLE;
      default:               state_nxt = lfu_sbc_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      lfu_sbc_pkg::S_IDLE:   in_ch.ready = 1'b1;
      lfu_sbc_pkg::S_SEARCH: load_out    = 1'b0;
      lfu_sbc_pkg::S_WAIT:   load_out    = out_free;
      default:               in_ch.ready = 1'b0;
    endcase
  end

  assign miss_evict = !fin_r.hit && !fin_r.empty;
  assign res_idx    = fin_r.hit   ? fin_r.hit_idx   :
                      fin_r.empty ? fin_r.empty_idx : fin_r.min_idx;

  always_comb begin
    upd.valid     = load_out;
    upd.idx       = res_idx;
    upd.hit       = fin_r.hit;
    upd.read_only = ro_r;
    upd.sector    = fin_r.sector;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ro_r <= in_ch.read_only;
    end
    if (chain[N].valid) begin
      fin_r <= chain[N];
    end
    if (load_out) begin
      slot_index_r  <= res_idx;
      was_hit_r     <= fin_r.hit;
      wb_needed_r   <= miss_evict && fin_r.min_dirty;
      wb_sector_r   <= (miss_evict && fin_r.min_dirty) ? fin_r.min_tag : '0;
      fill_needed_r <= !fin_r.hit;
    end
    if (!rst_n) begin
      state_r     <= lfu_sbc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.slot_index       = slot_index_r;
  assign out_ch.was_hit          = was_hit_r;
  assign out_ch.writeback_needed = wb_needed_r;
  assign out_ch.writeback_sector = wb_sector_r;
  assign out_ch.fill_needed      = fill_needed_r;

  // one transaction in flight along the chain
  `LSBC_ASSERT(a_single_token, $onehot0(tok_valid_vec))
  `LSBC_ASSERT(a_acc_to_search, in_acc |=> (state_r == lfu_sbc_pkg::S_SEARCH))
  `LSBC_NEVER(a_token_outside_search, chain[N].valid && (state_r != lfu_sbc_pkg::S_SEARCH))
  `LSBC_NEVER(a_hit_with_fill, out_valid_r && (was_hit_r == fill_needed_r))
  `LSBC_NEVER(a_hit_with_wb, out_valid_r && was_hit_r && wb_needed_r)

endmodule

`default_nettype wire

[rtl/lfu_sbc_cell.sv]
// one slot cell: holds tag, valid, use count and dirty mark of a slot
// and folds its slot into the passing search token; depends on lfu_sbc_pkg
`default_nettype none

module lfu_sbc_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lfu_sbc_pkg::idx_t cell_idx,
  input  wire lfu_sbc_pkg::tok_t tok_i,
  input  wire lfu_sbc_pkg::upd_t upd,
  output lfu_sbc_pkg::tok_t      tok_o
);

  lfu_sbc_pkg::sector_t tag_r,   tag_nxt;
  logic                 valid_r, valid_nxt;
  lfu_sbc_pkg::count_t  count_r, count_nxt;
  logic                 dirty_r, dirty_nxt;
  lfu_sbc_pkg::tok_t    tok_r,   tok_nxt;
  logic                 sel;

  assign sel = upd.valid && (upd.idx == cell_idx);

  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    dirty_nxt = dirty_r;
    if (sel) begin
      if (upd.hit) begin
        if (count_r != lfu_sbc_pkg::COUNT_MAX) begin
          count_nxt = count_r + lfu_sbc_pkg::count_t'(1);
        end
        if (!upd.read_only) begin
          dirty_nxt = 1'b1;
        end
      end else begin
        tag_nxt   = upd.sector;
        valid_nxt = 1'b1;
        count_nxt = '0;
        dirty_nxt = !upd.read_only;
      end
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    if (valid_r && (tag_r == tok_i.sector) && !tok_i.hit) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = cell_idx;
    end
    if (!valid_r && !tok_i.empty) begin
      tok_nxt.empty     = 1'b1;
      tok_nxt.empty_idx = cell_idx;
    end
    if (valid_r && (!tok_i.have_min || (count_r < tok_i.min_count))) begin
      tok_nxt.have_min  = 1'b1;
      tok_nxt.min_count = count_r;
      tok_nxt.min_idx   = cell_idx;
      tok_nxt.min_dirty = dirty_r;
      tok_nxt.min_tag   = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
      dirty_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      dirty_r <= dirty_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

[sim/tb_lfu_sector_buffer_cache.sv]
// testbench for lfu_sector_buffer_cache: drives requests, predicts lookups and checks results
// depends on lfu_sbc_pkg, lfu_sbc_in_if, lfu_sbc_out_if and the rtl top level
`default_nettype none

module tb_lfu_sector_buffer_cache;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4 * (lfu_sbc_pkg::SLOT_COUNT + 2);
  localparam int POOL_SIZE   = 12;
  localparam int HOT_HITS    = 40;

  typedef struct packed {
    lfu_sbc_pkg::idx_t    slot;
    logic                 hit;
    logic                 wb;
    lfu_sbc_pkg::sector_t wb_sector;
    logic                 fill;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  lfu_sbc_in_if  req_ch ();
  lfu_sbc_out_if rsp_ch ();

  lfu_sector_buffer_cache DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  lfu_sbc_pkg::sector_t slot_sector [lfu_sbc_pkg::SLOT_COUNT];
  logic                 slot_filled [lfu_sbc_pkg::SLOT_COUNT];
  lfu_sbc_pkg::count_t  slot_uses   [lfu_sbc_pkg::SLOT_COUNT];
  logic                 slot_dirty  [lfu_sbc_pkg::SLOT_COUNT];
  lookup_result_t       pending_lookups[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic lookup_result_t predict_lookup(input lfu_sbc_pkg::sector_t sector,
                                                    input logic rd_only);
    lookup_result_t r;
    int             victim;
    logic           found;
    r      = '0;
    found  = 1'b0;
    victim = -1;
    for (int i = 0; i < lfu_sbc_pkg::SLOT_COUNT; i++) begin
      if (!found && slot_filled[i] && slot_sector[i] == sector) begin
        found = 1'b1;
        r.slot = lfu_sbc_pkg::idx_t'(i);
        r.hit  = 1'b1;
        if (slot_uses[i] != lfu_sbc_pkg::COUNT_MAX)
          slot_uses[i] = slot_uses[i] + lfu_sbc_pkg::count_t'(1);
        if (!rd_only) slot_dirty[i] = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < lfu_sbc_pkg::SLOT_COUNT; i++) begin
        if (victim < 0 && !slot_filled[i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < lfu_sbc_pkg::SLOT_COUNT; i++) begin
          if (slot_uses[i] < slot_uses[victim]) victim = i;
        end
      end
      r.slot = lfu_sbc_pkg::idx_t'(victim);
      r.fill = 1'b1;
      if (slot_filled[victim] && slot_dirty[victim]) begin
        r.wb        = 1'b1;
        r.wb_sector = slot_sector[victim];
      end
      slot_sector[victim] = sector;
      slot_filled[victim] = 1'b1;
      slot_uses[victim]   = '0;
      slot_dirty[victim]  = !rd_only;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input lfu_sbc_pkg::sector_t sector, input logic rd_only);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.sector_number <= sector;
    req_ch.read_only     <= rd_only;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_lookups.push_back(predict_lookup(sector, rd_only));
  endtask

  task automatic wait_for_results;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no request waiting", 32'(rsp_ch.slot_index), 32'd0);
      end else begin
        lookup_result_t want;
        want = pending_lookups.pop_front();
        if (rsp_ch.slot_index !== want.slot)
          report_mismatch("slot_index", 32'(rsp_ch.slot_index), 32'(want.slot));
        if (rsp_ch.was_hit !== want.hit)
          report_mismatch("was_hit", 32'(rsp_ch.was_hit), 32'(want.hit));
        if (rsp_ch.writeback_needed !== want.wb)
          report_mismatch("writeback_needed", 32'(rsp_ch.writeback_needed), 32'(want.wb));
        if (rsp_ch.writeback_sector !== want.wb_sector)
          report_mismatch("writeback_sector", 32'(rsp_ch.writeback_sector),
                          32'(want.wb_sector));
        if (rsp_ch.fill_needed !== want.fill)
          report_mismatch("fill_needed", 32'(rsp_ch.fill_needed), 32'(want.fill));
      end
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_directed;
    send_request(10'd0, 1'b0);
    send_request(10'd1023, 1'b1);
    send_request(10'd0, 1'b1);
    send_request(10'd1023, 1'b0);
    send_request(10'h155, 1'b1);
    send_request(10'h2aa, 1'b1);
    send_request(10'h155, 1'b1);
    // empty slot taken although a valid slot has a lower count
    send_request(10'd5, 1'b1);
    send_request(10'd6, 1'b0);
    send_request(10'd7, 1'b0);
    send_request(10'd8, 1'b0);
    // full: clean victim, lowest index among equal counts
    send_request(10'd9, 1'b1);
    send_request(10'd10, 1'b1);
    send_request(10'd11, 1'b0);
    // dirty victim
    send_request(10'd12, 1'b1);
    send_request(10'd0, 1'b1);
    send_request(10'd1023, 1'b1);
    send_request(10'd7, 1'b1);
    send_request(10'd13, 1'b0);
    send_request(10'd14, 1'b1);
    wait_for_results();
  endtask

  task automatic test_hot_slot;
    lfu_sbc_pkg::sector_t hot;
    lfu_sbc_pkg::sector_t others[$];
    hot = 10'h3c3;
    send_request(hot, 1'b0);
    for (int i = 0; i < lfu_sbc_pkg::SLOT_COUNT; i++) begin
      if (slot_filled[i] && slot_sector[i] != hot) others.push_back(slot_sector[i]);
    end
    foreach (others[k]) begin
      send_request(others[k], 1'b1);
      send_request(others[k], 1'b0);
    end
    for (int n = 0; n < HOT_HITS; n++) begin
      send_request(hot, 1'($urandom_range(0, 1)));
    end
    // a frequently used slot outlives the eviction that follows
    send_request(10'h0f0, 1'b1);
    send_request(hot, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int items);
    lfu_sbc_pkg::sector_t pool[POOL_SIZE];
    lfu_sbc_pkg::sector_t sector;
    foreach (pool[k]) pool[k] = lfu_sbc_pkg::sector_t'($urandom_range(0, 1023));
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 75)
        sector = pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
      else
        sector = lfu_sbc_pkg::sector_t'($urandom_range(0, 1023));
      send_request(sector, 1'($urandom_range(0, 1)));
    end
    wait_for_results();
  endtask

  initial begin
    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.sector_number = '0;
    req_ch.read_only     = 1'b0;
    for (int i = 0; i < lfu_sbc_pkg::SLOT_COUNT; i++) begin
      slot_sector[i] = '0;
      slot_filled[i] = 1'b0;
      slot_uses[i]   = '0;
      slot_dirty[i]  = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 59;
    test_directed();
    test_random_traffic(460);

    send_idle_pct = 59;
    recv_idle_pct = 18;
    test_random_traffic(460);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(460);
    test_hot_slot();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
